/* design/assert_macros.svh */
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/s2rm_pkg.sv */
// types, constants and opcode tables of the two-register misc decoder
package s2rm_pkg;

    typedef enum logic [3:0] {
        RULE_ALL,
        RULE_SAME,
        RULE_PAIR,
        RULE_NARROW,
        RULE_SHLL,
        RULE_FSAME,
        RULE_FSAME_S,
        RULE_FNARROW,
        RULE_FWIDEN,
        RULE_BFN,
        RULE_XN,
        RULE_B8,
        RULE_B8WIDEN
    } t_rule;

    // arrangement codes
    localparam logic [2:0] ARR_8B  = 3'd0;
    localparam logic [2:0] ARR_8H  = 3'd3;
    localparam logic [2:0] ARR_4S  = 3'd5;
    localparam logic [2:0] ARR_2D  = 3'd7;

    // immediate kinds
    localparam logic [1:0] IMM_NONE  = 2'd0;
    localparam logic [1:0] IMM_ZERO  = 2'd1;
    localparam logic [1:0] IMM_SHIFT = 2'd2;

    // opcodes that keep the sz bit in the size table key
    localparam logic [4:0] OPC_KEEP_A = 5'b10111;
    localparam logic [4:0] OPC_KEEP_B = 5'b00101;
    localparam logic [4:0] OPC_KEEP_C = 5'b10110;

    // compare-with-zero opcode ranges
    localparam logic [4:0] OPC_CMZ_LO_A = 5'b01000;
    localparam logic [4:0] OPC_CMZ_HI_A = 5'b01010;
    localparam logic [4:0] OPC_CMZ_LO_B = 5'b01100;
    localparam logic [4:0] OPC_CMZ_HI_B = 5'b01110;

    // keys referenced by name elsewhere
    localparam logic [5:0] KEY_SHLL   = 6'b110011;
    localparam logic [7:0] KEY_BFCVTN = 8'b01010110;

    localparam logic [5:0] SHIFT_BASE = 6'd8;

    typedef struct packed {
        logic       q;
        logic       u;
        logic [1:0] szf;
        logic [4:0] opc;
        logic [4:0] rn;
        logic [4:0] rd;
    } t_fields;

    typedef struct packed {
        logic       hit;
        logic [6:0] code;
        logic       dual;
        t_rule      rule;
        logic [1:0] limit;
    } t_entry;

    function automatic t_entry ent(input logic [6:0] code, input logic dual,
                                   input t_rule rule, input logic [1:0] limit);
        t_entry e;
        e.hit   = 1'b1;
        e.code  = code;
        e.dual  = dual;
        e.rule  = rule;
        e.limit = limit;
        return e;
    endfunction

    function automatic t_entry int_lookup(input logic [5:0] key);
        t_entry e;
        e = '0;
        case (key)
            6'h00:    e = ent(7'd0,  1'b0, RULE_ALL,    2'd3);
            6'h01:    e = ent(7'd1,  1'b0, RULE_ALL,    2'd1);
            6'h02:    e = ent(7'd2,  1'b0, RULE_PAIR,   2'd0);
            6'h03:    e = ent(7'd3,  1'b0, RULE_SAME,   2'd0);
            6'h04:    e = ent(7'd4,  1'b0, RULE_ALL,    2'd3);
            6'h05:    e = ent(7'd5,  1'b0, RULE_ALL,    2'd1);
            6'h06:    e = ent(7'd6,  1'b0, RULE_PAIR,   2'd0);
            6'h07:    e = ent(7'd7,  1'b0, RULE_SAME,   2'd0);
            6'h08:    e = ent(7'd8,  1'b0, RULE_SAME,   2'd0);
            6'h09:    e = ent(7'd9,  1'b0, RULE_SAME,   2'd0);
            6'h0A:    e = ent(7'd10, 1'b0, RULE_SAME,   2'd0);
            6'h0B:    e = ent(7'd11, 1'b0, RULE_SAME,   2'd0);
            6'h12:    e = ent(7'd12, 1'b1, RULE_NARROW, 2'd0);
            6'h14:    e = ent(7'd14, 1'b1, RULE_NARROW, 2'd0);
            6'h20:    e = ent(7'd16, 1'b0, RULE_ALL,    2'd2);
            6'h22:    e = ent(7'd17, 1'b0, RULE_PAIR,   2'd0);
            6'h23:    e = ent(7'd18, 1'b0, RULE_SAME,   2'd0);
            6'h24:    e = ent(7'd19, 1'b0, RULE_ALL,    2'd3);
            6'h26:    e = ent(7'd20, 1'b0, RULE_PAIR,   2'd0);
            6'h27:    e = ent(7'd21, 1'b0, RULE_SAME,   2'd0);
            6'h28:    e = ent(7'd22, 1'b0, RULE_SAME,   2'd0);
            6'h29:    e = ent(7'd23, 1'b0, RULE_SAME,   2'd0);
            6'h2B:    e = ent(7'd24, 1'b0, RULE_SAME,   2'd0);
            6'h32:    e = ent(7'd25, 1'b1, RULE_NARROW, 2'd0);
            KEY_SHLL: e = ent(7'd27, 1'b1, RULE_SHLL,   2'd0);
            6'h34:    e = ent(7'd29, 1'b1, RULE_NARROW, 2'd0);
            default:  e = '0;
        endcase
        return e;
    endfunction

    function automatic t_entry size_lookup(input logic [7:0] key);
        t_entry e;
        e = '0;
        case (key)
            8'h16:      e = ent(7'd31, 1'b1, RULE_FNARROW, 2'd0);
            8'h17:      e = ent(7'd33, 1'b1, RULE_FWIDEN,  2'd0);
            8'h18:      e = ent(7'd35, 1'b0, RULE_FSAME,   2'd0);
            8'h19:      e = ent(7'd36, 1'b0, RULE_FSAME,   2'd0);
            8'h1A:      e = ent(7'd37, 1'b0, RULE_FSAME,   2'd0);
            8'h1B:      e = ent(7'd38, 1'b0, RULE_FSAME,   2'd0);
            8'h1C:      e = ent(7'd39, 1'b0, RULE_FSAME,   2'd0);
            8'h1D:      e = ent(7'd40, 1'b0, RULE_FSAME,   2'd0);
            8'h1E:      e = ent(7'd41, 1'b0, RULE_FSAME,   2'd0);
            8'h1F:      e = ent(7'd42, 1'b0, RULE_FSAME,   2'd0);
            8'h4C:      e = ent(7'd43, 1'b0, RULE_FSAME,   2'd0);
            8'h4D:      e = ent(7'd44, 1'b0, RULE_FSAME,   2'd0);
            8'h4E:      e = ent(7'd45, 1'b0, RULE_FSAME,   2'd0);
            8'h4F:      e = ent(7'd46, 1'b0, RULE_FSAME,   2'd0);
            8'h58:      e = ent(7'd47, 1'b0, RULE_FSAME,   2'd0);
            8'h59:      e = ent(7'd48, 1'b0, RULE_FSAME,   2'd0);
            8'h5A:      e = ent(7'd49, 1'b0, RULE_FSAME,   2'd0);
            8'h5B:      e = ent(7'd50, 1'b0, RULE_FSAME,   2'd0);
            8'h5C:      e = ent(7'd51, 1'b0, RULE_FSAME_S, 2'd0);
            8'h5D:      e = ent(7'd52, 1'b0, RULE_FSAME,   2'd0);
            KEY_BFCVTN: e = ent(7'd53, 1'b1, RULE_BFN,     2'd0);
            8'h98:      e = ent(7'd55, 1'b0, RULE_FSAME,   2'd0);
            8'h99:      e = ent(7'd56, 1'b0, RULE_FSAME,   2'd0);
            8'h9A:      e = ent(7'd57, 1'b0, RULE_FSAME,   2'd0);
            8'h9B:      e = ent(7'd58, 1'b0, RULE_FSAME,   2'd0);
            8'h9C:      e = ent(7'd59, 1'b0, RULE_FSAME,   2'd0);
            8'h9D:      e = ent(7'd60, 1'b0, RULE_FSAME,   2'd0);
            8'h9E:      e = ent(7'd61, 1'b0, RULE_FSAME,   2'd0);
            8'h9F:      e = ent(7'd62, 1'b0, RULE_FSAME,   2'd0);
            8'h85:      e = ent(7'd63, 1'b0, RULE_B8,      2'd0);
            8'h97:      e = ent(7'd64, 1'b1, RULE_B8WIDEN, 2'd0);
            8'hA5:      e = ent(7'd66, 1'b0, RULE_B8,      2'd0);
            8'hB6:      e = ent(7'd67, 1'b1, RULE_XN,      2'd0);
            8'hB7:      e = ent(7'd69, 1'b1, RULE_B8WIDEN, 2'd0);
            8'hCC:      e = ent(7'd71, 1'b0, RULE_FSAME,   2'd0);
            8'hCD:      e = ent(7'd72, 1'b0, RULE_FSAME,   2'd0);
            8'hCF:      e = ent(7'd73, 1'b0, RULE_FSAME,   2'd0);
            8'hD9:      e = ent(7'd74, 1'b0, RULE_FSAME,   2'd0);
            8'hDA:      e = ent(7'd75, 1'b0, RULE_FSAME,   2'd0);
            8'hDB:      e = ent(7'd76, 1'b0, RULE_FSAME,   2'd0);
            8'hDC:      e = ent(7'd77, 1'b0, RULE_FSAME_S, 2'd0);
            8'hDD:      e = ent(7'd78, 1'b0, RULE_FSAME,   2'd0);
            8'hDF:      e = ent(7'd79, 1'b0, RULE_FSAME,   2'd0);
            8'hD7:      e = ent(7'd80, 1'b1, RULE_B8WIDEN, 2'd0);
            8'hF7:      e = ent(7'd82, 1'b1, RULE_B8WIDEN, 2'd0);
            default:    e = '0;
        endcase
        return e;
    endfunction

endpackage

/* design/s2rm_lookup.sv */
// opcode table lookup: integer table first, size table on a miss
module s2rm_lookup (
    input  s2rm_pkg::t_fields i_fields,
    output s2rm_pkg::t_entry  o_entry
);

    logic                keep_sz;
    logic [7:0]          size_key;
    s2rm_pkg::t_entry    int_e;
    s2rm_pkg::t_entry    size_e;

    // a few encodings keep the low size bit in the key
    assign keep_sz = (i_fields.u && (i_fields.opc == s2rm_pkg::OPC_KEEP_A ||
                                     i_fields.opc == s2rm_pkg::OPC_KEEP_B ||
                                     i_fields.opc == s2rm_pkg::OPC_KEEP_C))
                  || (!i_fields.u && i_fields.opc == s2rm_pkg::OPC_KEEP_C &&
                      i_fields.szf[1]);

    assign size_key = {i_fields.u, i_fields.szf[1], i_fields.szf[0] & keep_sz,
                       i_fields.opc};

    assign int_e  = s2rm_pkg::int_lookup({i_fields.u, i_fields.opc});
    assign size_e = s2rm_pkg::size_lookup(size_key);

    assign o_entry = int_e.hit ? int_e : size_e;

endmodule

/* design/simd_two_reg_misc_decoder_unit.sv */
// top level of the two-register misc vector instruction decoder pipeline
//
// usage
//   input channel: i_valid / o_stall with i_instruction_word; an item is taken
//   at a clock edge where i_valid is high and o_stall is low
//   output channel: o_valid / i_stall with the decoded fields; a result is
//   taken at an edge where o_valid is high and i_stall is low
//   a word taken at an edge passes the field capture, table lookup and
//   arrangement rules registers in that order before it shows on the outputs
//   throughput: one item per cycle while i_stall is low, set by three register
//   stages (field capture, table lookup, arrangement rules) with no loop between them
//   stall: a high i_stall freezes the output register; empty stages still
//   fill, so o_stall rises only when all three stages hold an item
//   reset: synchronous, active low; clears all stage valid bits, nothing else
//   is initialized and no clearing pass is needed
//   decode_error marks unknown encodings and reserved arrangements, and then
//   every other output field reads zero
module simd_two_reg_misc_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instruction_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_decode_error,
    output logic [6:0]  o_instruction_code,
    output logic [4:0]  o_dest_register,
    output logic [4:0]  o_source_register,
    output logic [2:0]  o_dest_arrangement,
    output logic [2:0]  o_source_arrangement,
    output logic [1:0]  o_immediate_kind,
    output logic [5:0]  o_shift_amount
);

    `include "assert_macros.svh"

    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    logic                en1;
    logic                en2;
    logic                en3;

    s2rm_pkg::t_fields   in_fields;
    s2rm_pkg::t_fields   r_s1;
    s2rm_pkg::t_entry    lookup_e;
    s2rm_pkg::t_fields   r_s2_f;
    s2rm_pkg::t_entry    r_s2_e;

    logic                ok;
    logic [2:0]          da;
    logic [2:0]          sa;
    logic [1:0]          kind;
    logic [5:0]          sh;
    logic [2:0]          szf_p1;
    logic                cmz;

    logic                n_decode_error;
    logic [6:0]          n_instruction_code;
    logic [4:0]          n_dest_register;
    logic [4:0]          n_source_register;
    logic [2:0]          n_dest_arrangement;
    logic [2:0]          n_source_arrangement;
    logic [1:0]          n_immediate_kind;
    logic [5:0]          n_shift_amount;

    logic                r_decode_error;
    logic [6:0]          r_instruction_code;
    logic [4:0]          r_dest_register;
    logic [4:0]          r_source_register;
    logic [2:0]          r_dest_arrangement;
    logic [2:0]          r_source_arrangement;
    logic [1:0]          r_immediate_kind;
    logic [5:0]          r_shift_amount;

    // a stage moves when it is empty or the stage after it moves
    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage 1: field capture
    assign in_fields.q   = i_instruction_word[30];
    assign in_fields.u   = i_instruction_word[29];
    assign in_fields.szf = i_instruction_word[23:22];
    assign in_fields.opc = i_instruction_word[16:12];
    assign in_fields.rn  = i_instruction_word[9:5];
    assign in_fields.rd  = i_instruction_word[4:0];

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= in_fields;
        end
    end

    // stage 2: table lookup
    s2rm_lookup u_lookup (
        .i_fields (r_s1),
        .o_entry  (lookup_e)
    );

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_f <= r_s1;
            r_s2_e <= lookup_e;
        end
    end

    // stage 3: arrangement rules
    assign szf_p1 = {1'b0, r_s2_f.szf} + 3'd1;
    assign cmz    = (r_s2_f.opc >= s2rm_pkg::OPC_CMZ_LO_A &&
                     r_s2_f.opc <= s2rm_pkg::OPC_CMZ_HI_A) ||
                    (r_s2_f.opc >= s2rm_pkg::OPC_CMZ_LO_B &&
                     r_s2_f.opc <= s2rm_pkg::OPC_CMZ_HI_B);

    always_comb begin
        ok   = r_s2_e.hit;
        da   = {r_s2_f.szf, r_s2_f.q};
        sa   = {r_s2_f.szf, r_s2_f.q};
        kind = s2rm_pkg::IMM_NONE;
        sh   = '0;
        case (r_s2_e.rule)
            s2rm_pkg::RULE_ALL: begin
                ok = r_s2_e.hit && (r_s2_f.szf < r_s2_e.limit);
            end
            s2rm_pkg::RULE_SAME: begin
                ok = r_s2_e.hit && !(r_s2_f.szf == 2'd3 && !r_s2_f.q);
            end
            s2rm_pkg::RULE_PAIR: begin
                ok = r_s2_e.hit && (r_s2_f.szf != 2'd3);
                da = {szf_p1[1:0], r_s2_f.q};
            end
            s2rm_pkg::RULE_NARROW: begin
                ok = r_s2_e.hit && (r_s2_f.szf != 2'd3);
                sa = {szf_p1[1:0], 1'b1};
            end
            s2rm_pkg::RULE_SHLL: begin
                ok   = r_s2_e.hit && (r_s2_f.szf != 2'd3);
                da   = {szf_p1[1:0], 1'b1};
                kind = s2rm_pkg::IMM_SHIFT;
                sh   = s2rm_pkg::SHIFT_BASE << r_s2_f.szf;
            end
            s2rm_pkg::RULE_FSAME: begin
                ok = r_s2_e.hit && !(r_s2_f.szf[0] && !r_s2_f.q);
                da = {1'b1, r_s2_f.szf[0], r_s2_f.q};
                sa = {1'b1, r_s2_f.szf[0], r_s2_f.q};
            end
            s2rm_pkg::RULE_FSAME_S: begin
                ok = r_s2_e.hit && !r_s2_f.szf[0];
                da = {1'b1, r_s2_f.szf[0], r_s2_f.q};
                sa = {1'b1, r_s2_f.szf[0], r_s2_f.q};
            end
            s2rm_pkg::RULE_FNARROW: begin
                da = r_s2_f.szf[0] ? {2'b10, r_s2_f.q} : {2'b01, r_s2_f.q};
                sa = r_s2_f.szf[0] ? s2rm_pkg::ARR_2D : s2rm_pkg::ARR_4S;
            end
            s2rm_pkg::RULE_FWIDEN: begin
                da = r_s2_f.szf[0] ? s2rm_pkg::ARR_2D : s2rm_pkg::ARR_4S;
                sa = r_s2_f.szf[0] ? {2'b10, r_s2_f.q} : {2'b01, r_s2_f.q};
            end
            s2rm_pkg::RULE_BFN: begin
                da = {2'b01, r_s2_f.q};
                sa = s2rm_pkg::ARR_4S;
            end
            s2rm_pkg::RULE_XN: begin
                da = {2'b10, r_s2_f.q};
                sa = s2rm_pkg::ARR_2D;
            end
            s2rm_pkg::RULE_B8: begin
                da = {2'b00, r_s2_f.q};
                sa = {2'b00, r_s2_f.q};
            end
            s2rm_pkg::RULE_B8WIDEN: begin
                da = s2rm_pkg::ARR_8H;
                sa = {2'b00, r_s2_f.q};
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (ok) begin
            n_decode_error       = 1'b0;
            n_instruction_code   = r_s2_e.code + {6'd0, r_s2_e.dual & r_s2_f.q};
            n_dest_register      = r_s2_f.rd;
            n_source_register    = r_s2_f.rn;
            n_dest_arrangement   = da;
            n_source_arrangement = sa;
            n_immediate_kind     = cmz ? s2rm_pkg::IMM_ZERO : kind;
            n_shift_amount       = sh;
        end else begin
            n_decode_error       = 1'b1;
            n_instruction_code   = '0;
            n_dest_register      = '0;
            n_source_register    = '0;
            n_dest_arrangement   = s2rm_pkg::ARR_8B;
            n_source_arrangement = s2rm_pkg::ARR_8B;
            n_immediate_kind     = s2rm_pkg::IMM_NONE;
            n_shift_amount       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_decode_error       <= n_decode_error;
            r_instruction_code   <= n_instruction_code;
            r_dest_register      <= n_dest_register;
            r_source_register    <= n_source_register;
            r_dest_arrangement   <= n_dest_arrangement;
            r_source_arrangement <= n_source_arrangement;
            r_immediate_kind     <= n_immediate_kind;
            r_shift_amount       <= n_shift_amount;
        end
    end

    assign o_valid              = r_v3;
    assign o_decode_error       = r_decode_error;
    assign o_instruction_code   = r_instruction_code;
    assign o_dest_register      = r_dest_register;
    assign o_source_register    = r_source_register;
    assign o_dest_arrangement   = r_dest_arrangement;
    assign o_source_arrangement = r_source_arrangement;
    assign o_immediate_kind     = r_immediate_kind;
    assign o_shift_amount       = r_shift_amount;

    // error results carry no other information
    `ASSERT_CLK(a_err_zero, i_clk, i_rst_n,
        o_valid && o_decode_error |-> o_instruction_code == 7'd0 &&
        o_dest_register == 5'd0 && o_source_register == 5'd0 &&
        o_immediate_kind == s2rm_pkg::IMM_NONE && o_shift_amount == 6'd0,
        "error result with nonzero fields")

    // shift immediate only with a legal element size
    `ASSERT_CLK(a_shift_amt, i_clk, i_rst_n,
        o_valid && o_immediate_kind == s2rm_pkg::IMM_SHIFT |->
        o_shift_amount == 6'd8 || o_shift_amount == 6'd16 || o_shift_amount == 6'd32,
        "shift immediate out of range")

    // back-pressure only when every stage holds an item
    `ASSERT_CLK(a_stall_full, i_clk, i_rst_n,
        o_stall |-> r_v1 && r_v2 && r_v3 && i_stall,
        "input stalled while pipeline has room")

    `ASSERT_CLK_ALWAYS(a_rst_empty, i_clk,
        !i_rst_n |=> !o_valid,
        "output valid right after reset")

endmodule
